// ===== hdl/rgbnv_pkg.sv =====
`timescale 1ns / 1ps

package rgbnv_pkg;

    // Field widths
    localparam int C_WORD_W       = 32;
    localparam int C_COORD_W      = 11;
    localparam int C_DIM_W        = 12;
    localparam int C_SAMPLE_W     = 8;
    localparam int C_LUMA_IDX_W   = 22;
    localparam int C_CHROMA_IDX_W = 21;
    localparam int C_FMT_W        = 2;
    localparam int C_CFG_IDX_W    = 2;

    // Frame size limits
    localparam int C_MAX_WIDTH  = 2048;
    localparam int C_MAX_HEIGHT = 2048;

    // Register reset values
    localparam int C_RST_WIDTH  = 854;
    localparam int C_RST_HEIGHT = 480;

    // Pixel format codes; the unused code falls back to RGBA8
    typedef enum logic [C_FMT_W-1:0] {
        FMT_RGBA8       = 2'd0,
        FMT_BGRA8       = 2'd1,
        FMT_A2B10G10R10 = 2'd2
    } t_pixel_format;

    // Configuration register indexes
    typedef enum logic [C_CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_PIXEL_FORMAT = 2'd2
    } t_cfg_index;

endpackage

// ===== hdl/rgbnv_pix_if.sv =====
`timescale 1ns / 1ps

interface rgbnv_pix_if;
    import rgbnv_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [C_WORD_W-1:0]  pixel_word;
    logic [C_COORD_W-1:0] column;
    logic [C_COORD_W-1:0] row;

    modport source (output valid, pixel_word, column, row, input ready);
    modport sink   (input valid, pixel_word, column, row, output ready);
endinterface

// ===== hdl/rgbnv_res_if.sv =====
`timescale 1ns / 1ps

interface rgbnv_res_if;
    import rgbnv_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [C_SAMPLE_W-1:0]     luma;
    logic [C_LUMA_IDX_W-1:0]   luma_index;
    logic                      chroma_valid;
    logic [C_SAMPLE_W-1:0]     cb_sample;
    logic [C_SAMPLE_W-1:0]     cr_sample;
    logic [C_CHROMA_IDX_W-1:0] chroma_index;
    logic                      frame_end;

    modport source (output valid, luma, luma_index, chroma_valid, cb_sample, cr_sample,
                    chroma_index, frame_end, input ready);
    modport sink   (input valid, luma, luma_index, chroma_valid, cb_sample, cr_sample,
                    chroma_index, frame_end, output ready);
endinterface

// ===== hdl/rgbnv_rescale.sv =====
`timescale 1ns / 1ps

module rgbnv_rescale (
    input  logic [9:0] i_chan,
    output logic [7:0] o_chan
);
    // Rounded rescale (c*255 + 511) / 1023. The quotient by 1024 is at most
    // one short of the quotient by 1023, so one compare fixes it up.
    logic [17:0] w_num;
    logic [7:0]  w_q0;
    logic [10:0] w_rem;

    assign w_num = {i_chan, 8'd0} - {8'd0, i_chan} + 18'd511;
    assign w_q0  = w_num[17:10];
    // Remainder against 1023: x - q0*1024 + q0
    assign w_rem = {1'b0, w_num[9:0]} + {3'd0, w_q0};

    assign o_chan = (w_rem >= 11'd1023) ? w_q0 + 8'd1 : w_q0;
endmodule

// ===== hdl/rgb_to_nv12_pixel_converter.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake     Payload
// i_pix     in   valid/ready   pixel_word, column, row
// o_res     out  valid/ready   luma, luma_index, chroma_valid, cb_sample, cr_sample,
//                              chroma_index, frame_end
// i_cfg_*   in   write enable  frame_width, frame_height, pixel_format
//
// One pixel per clock sustained while the output is not stalled.
// Stages: unpack and 10-bit rescale, color sums and index multiplies, shift and clamp.
// Synchronous active-low reset clears the valid bits and loads 854 x 480, RGBA8.
// A stall at the output freezes all stages together; ready in follows it directly.

module rgb_to_nv12_pixel_converter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [rgbnv_pkg::C_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rgbnv_pkg::C_DIM_W-1:0]     i_cfg_data,
    rgbnv_pix_if.sink                         i_pix,
    rgbnv_res_if.source                       o_res
);
    import rgbnv_pkg::*;

    // Clamp a widened sample into [lo, hi]
    function automatic logic [C_SAMPLE_W-1:0] clamp8(
        input logic [C_SAMPLE_W:0] v,
        input logic [C_SAMPLE_W:0] lo,
        input logic [C_SAMPLE_W:0] hi
    );
        logic [C_SAMPLE_W:0] t;
        t = (v < lo) ? lo : ((v > hi) ? hi : v);
        return t[C_SAMPLE_W-1:0];
    endfunction

    // Configuration registers
    logic [C_DIM_W-1:0] r_frame_width;
    logic [C_DIM_W-1:0] r_frame_height;
    t_pixel_format      r_pixel_format;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= C_DIM_W'(C_RST_WIDTH);
            r_frame_height <= C_DIM_W'(C_RST_HEIGHT);
            r_pixel_format <= FMT_RGBA8;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                CFG_PIXEL_FORMAT: r_pixel_format <= t_pixel_format'(i_cfg_data[C_FMT_W-1:0]);
                default: ;
            endcase
        end
    end

    // Effective dimensions: drop bit 0, saturate at the maximum
    logic [C_DIM_W-1:0] w_width;
    logic [C_DIM_W-1:0] w_height;
    logic [C_DIM_W-1:0] w_width_even;
    logic [C_DIM_W-1:0] w_height_even;

    assign w_width_even  = {r_frame_width[C_DIM_W-1:1], 1'b0};
    assign w_height_even = {r_frame_height[C_DIM_W-1:1], 1'b0};
    assign w_width  = (w_width_even > C_DIM_W'(C_MAX_WIDTH)) ?
                      C_DIM_W'(C_MAX_WIDTH) : w_width_even;
    assign w_height = (w_height_even > C_DIM_W'(C_MAX_HEIGHT)) ?
                      C_DIM_W'(C_MAX_HEIGHT) : w_height_even;

    // Advance every stage unless the output holds an untaken result
    logic w_adv;
    assign w_adv       = !o_res.valid || o_res.ready;
    assign i_pix.ready = w_adv;

    // ---------------- Stage 1: unpack ----------------
    logic [C_SAMPLE_W-1:0] w_r10;
    logic [C_SAMPLE_W-1:0] w_g10;
    logic [C_SAMPLE_W-1:0] w_b10;
    logic [C_SAMPLE_W-1:0] n_s1_r;
    logic [C_SAMPLE_W-1:0] n_s1_g;
    logic [C_SAMPLE_W-1:0] n_s1_b;
    logic                  n_s1_end;

    rgbnv_rescale u_rescale_r (.i_chan(i_pix.pixel_word[9:0]),   .o_chan(w_r10));
    rgbnv_rescale u_rescale_g (.i_chan(i_pix.pixel_word[19:10]), .o_chan(w_g10));
    rgbnv_rescale u_rescale_b (.i_chan(i_pix.pixel_word[29:20]), .o_chan(w_b10));

    // Select channels by format
    always_comb begin
        n_s1_g = i_pix.pixel_word[15:8];
        n_s1_r = i_pix.pixel_word[7:0];
        n_s1_b = i_pix.pixel_word[23:16];
        unique case (r_pixel_format)
            FMT_BGRA8: begin
                n_s1_r = i_pix.pixel_word[23:16];
                n_s1_b = i_pix.pixel_word[7:0];
            end
            FMT_A2B10G10R10: begin
                n_s1_r = w_r10;
                n_s1_g = w_g10;
                n_s1_b = w_b10;
            end
            default: ;
        endcase
    end

    // Flag the last pixel of the frame
    assign n_s1_end = (w_width != '0) && (w_height != '0) &&
                      (({1'b0, i_pix.column} + C_DIM_W'(1)) == w_width) &&
                      (({1'b0, i_pix.row} + C_DIM_W'(1)) == w_height);

    logic                  r_s1_valid;
    logic [C_SAMPLE_W-1:0] r_s1_r;
    logic [C_SAMPLE_W-1:0] r_s1_g;
    logic [C_SAMPLE_W-1:0] r_s1_b;
    logic [C_COORD_W-1:0]  r_s1_col;
    logic [C_COORD_W-1:0]  r_s1_row;
    logic                  r_s1_chroma;
    logic                  r_s1_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_r      <= n_s1_r;
            r_s1_g      <= n_s1_g;
            r_s1_b      <= n_s1_b;
            r_s1_col    <= i_pix.column;
            r_s1_row    <= i_pix.row;
            r_s1_chroma <= !i_pix.column[0] && !i_pix.row[0];
            r_s1_end    <= n_s1_end;
        end
    end

    // ---------------- Stage 2: color sums and index multiplies ----------------
    logic [15:0]                 n_s2_ysum;
    logic [16:0]                 w_usum17;
    logic [16:0]                 w_vsum17;
    logic [C_LUMA_IDX_W:0]       w_luma_prod;
    logic [C_LUMA_IDX_W-1:0]     w_chroma_prod;
    logic [C_LUMA_IDX_W-1:0]     n_s2_luma_idx;
    logic [C_CHROMA_IDX_W-1:0]   n_s2_chroma_idx;

    // Luma sum with rounding; chroma sums carry a bias of 128*256 + 128
    assign n_s2_ysum = 16'd66 * {8'd0, r_s1_r} + 16'd129 * {8'd0, r_s1_g}
                     + 16'd25 * {8'd0, r_s1_b} + 16'd128;
    assign w_usum17  = 17'd112 * {9'd0, r_s1_b} + 17'd32896
                     - 17'd38 * {9'd0, r_s1_r} - 17'd74 * {9'd0, r_s1_g};
    assign w_vsum17  = 17'd112 * {9'd0, r_s1_r} + 17'd32896
                     - 17'd94 * {9'd0, r_s1_g} - 17'd18 * {9'd0, r_s1_b};

    // Plane indices, wrapped at their field widths
    assign w_luma_prod     = {12'd0, r_s1_row} * {11'd0, w_width};
    assign w_chroma_prod   = {12'd0, r_s1_row[C_COORD_W-1:1]} * {10'd0, w_width};
    assign n_s2_luma_idx   = w_luma_prod[C_LUMA_IDX_W-1:0] + C_LUMA_IDX_W'(r_s1_col);
    assign n_s2_chroma_idx = w_chroma_prod[C_CHROMA_IDX_W-1:0] + C_CHROMA_IDX_W'(r_s1_col);

    logic                      r_s2_valid;
    logic [15:0]               r_s2_ysum;
    logic [15:0]               r_s2_usum;
    logic [15:0]               r_s2_vsum;
    logic [C_LUMA_IDX_W-1:0]   r_s2_luma_idx;
    logic [C_CHROMA_IDX_W-1:0] r_s2_chroma_idx;
    logic                      r_s2_chroma;
    logic                      r_s2_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_ysum       <= n_s2_ysum;
            r_s2_usum       <= w_usum17[15:0];
            r_s2_vsum       <= w_vsum17[15:0];
            r_s2_luma_idx   <= n_s2_luma_idx;
            r_s2_chroma_idx <= n_s2_chroma_idx;
            r_s2_chroma     <= r_s1_chroma;
            r_s2_end        <= r_s1_end;
        end
    end

    // ---------------- Stage 3: shift, clamp, output register ----------------
    logic [C_SAMPLE_W-1:0] n_s3_luma;
    logic [C_SAMPLE_W-1:0] n_s3_cb;
    logic [C_SAMPLE_W-1:0] n_s3_cr;

    assign n_s3_luma = clamp8({1'b0, r_s2_ysum[15:8]} + 9'd16, 9'd16, 9'd235);
    assign n_s3_cb   = r_s2_chroma ? clamp8({1'b0, r_s2_usum[15:8]}, 9'd16, 9'd240) : 8'd128;
    assign n_s3_cr   = r_s2_chroma ? clamp8({1'b0, r_s2_vsum[15:8]}, 9'd16, 9'd240) : 8'd128;

    logic                      r_s3_valid;
    logic [C_SAMPLE_W-1:0]     r_s3_luma;
    logic [C_LUMA_IDX_W-1:0]   r_s3_luma_idx;
    logic                      r_s3_chroma;
    logic [C_SAMPLE_W-1:0]     r_s3_cb;
    logic [C_SAMPLE_W-1:0]     r_s3_cr;
    logic [C_CHROMA_IDX_W-1:0] r_s3_chroma_idx;
    logic                      r_s3_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_adv) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_luma       <= n_s3_luma;
            r_s3_luma_idx   <= r_s2_luma_idx;
            r_s3_chroma     <= r_s2_chroma;
            r_s3_cb         <= n_s3_cb;
            r_s3_cr         <= n_s3_cr;
            r_s3_chroma_idx <= r_s2_chroma ? r_s2_chroma_idx : '0;
            r_s3_end        <= r_s2_end;
        end
    end

    // Drive the result channel
    assign o_res.valid        = r_s3_valid;
    assign o_res.luma         = r_s3_luma;
    assign o_res.luma_index   = r_s3_luma_idx;
    assign o_res.chroma_valid = r_s3_chroma;
    assign o_res.cb_sample    = r_s3_cb;
    assign o_res.cr_sample    = r_s3_cr;
    assign o_res.chroma_index = r_s3_chroma_idx;
    assign o_res.frame_end    = r_s3_end;

endmodule
